>>> hdl/asfc_pkg.sv
// Shared types, constants and helper functions for the audio sample format converter.
package asfc_pkg;

    // Word widths of the sample path.
    localparam int WORD_W = 16;
    localparam int VAL_W  = 17;
    localparam int DITHER_W = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 5;

    // Default upper bound on the downsample group size.
    localparam int MAX_SCALE_DEF = 16;

    // Sign bit flip mask and dither reset value.
    localparam logic [WORD_W-1:0]   SIGN_MASK   = 16'h8000;
    localparam logic [DITHER_W-1:0] DITHER_INIT = 8'd32;

    // Clamp limits of the 8-bit requantizer, in the 18-bit sum domain.
    localparam logic signed [VAL_W:0] S_MIN = -18'sd32768;
    localparam logic signed [VAL_W:0] S_MAX = 18'sd32767;
    localparam logic signed [VAL_W:0] U_MAX = 18'sd65535;

    // Bytes that the clamped extremes produce.
    localparam logic [7:0] BYTE_S_MIN = 8'h80;
    localparam logic [7:0] BYTE_S_MAX = 8'h7F;
    localparam logic [7:0] BYTE_U_MIN = 8'h00;
    localparam logic [7:0] BYTE_U_MAX = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_DELTA   = 3'd0,
        CFG_IN_SIGNED  = 3'd1,
        CFG_IN_STEREO  = 3'd2,
        CFG_OUT_DELTA  = 3'd3,
        CFG_OUT_SIGNED = 3'd4,
        CFG_OUT_STEREO = 3'd5,
        CFG_OUT_WIDE   = 3'd6,
        CFG_SCALE      = 3'd7
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_GROUP,
        ST_DIV,
        ST_DELTA,
        ST_QUANT,
        ST_SEND
    } t_state;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic ld_in;
        logic prep;
        logic grp_bypass;
        logic grp_close;
        logic grp_acc;
        logic to_second;
        logic ld_quot;
        logic do_delta;
        logic ld_out;
        logic out_done;
    } t_ctrl;

    // Reads a 16-bit word as a signed value or as an unsigned value.
    function automatic logic signed [VAL_W-1:0] as_value(input logic [WORD_W-1:0] w,
                                                         input logic sgn);
        as_value = sgn ? $signed({w[WORD_W-1], w}) : $signed({1'b0, w});
    endfunction

endpackage

>>> hdl/asfc_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
module asfc_div #(
    parameter int SUM_W = 22,
    parameter int CNT_W = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [SUM_W-1:0]               i_dividend,
    input  logic [CNT_W-1:0]                      i_divisor,
    output logic                                  o_done,
    output logic signed [asfc_pkg::VAL_W-1:0]     o_quot
);

    localparam int MAG_W  = SUM_W - 1;
    localparam int STEP_W = $clog2(MAG_W + 1);

    logic                     r_busy;
    logic                     r_done;
    logic [STEP_W-1:0]        r_step;
    logic                     r_neg;
    logic [CNT_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_dvd;
    logic [CNT_W-1:0]         r_dsr;

    logic signed [SUM_W-1:0]  neg_v;
    logic signed [SUM_W-1:0]  abs_v;
    logic [CNT_W:0]           trial;
    logic [CNT_W:0]           diff;
    logic                     ge;
    logic [asfc_pkg::VAL_W-1:0] q_mag;
    logic [asfc_pkg::VAL_W-1:0] q_neg;

    // Magnitude of the dividend at start.
    assign neg_v = -i_dividend;
    assign abs_v = i_dividend[SUM_W-1] ? neg_v : i_dividend;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {r_rem, r_dvd[MAG_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign ge    = (trial >= {1'b0, r_dsr});

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(MAG_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register; the quotient replaces the dividend bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_rem <= '0;
            r_dvd <= abs_v[MAG_W-1:0];
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            r_dvd <= {r_dvd[MAG_W-2:0], ge};
        end
    end

    // Apply the sign to the quotient magnitude.
    assign q_mag  = r_dvd[asfc_pkg::VAL_W-1:0];
    assign q_neg  = -q_mag;
    assign o_quot = r_neg ? $signed(q_neg) : $signed(q_mag);
    assign o_done = r_done;

endmodule

>>> hdl/asfc_quant.sv
// Output formatter: passes 16-bit words or requantizes to 8 bits with clamp and error feedback.
module asfc_quant (
    input  logic signed [asfc_pkg::VAL_W-1:0]    i_val,
    input  logic [asfc_pkg::DITHER_W-1:0]        i_dither,
    input  logic                                 i_out_signed,
    input  logic                                 i_out_wide,
    output logic [asfc_pkg::WORD_W-1:0]          o_word,
    output logic [asfc_pkg::DITHER_W-1:0]        o_dither
);

    logic signed [asfc_pkg::VAL_W:0] eep;
    logic [7:0]                      byte_v;

    // Sample plus the carried error; its low byte is the next error.
    assign eep      = asfc_pkg::VAL_W'(i_val) + $signed({10'b0, i_dither});
    assign o_dither = eep[7:0];

    // Clamp to the output range and take the high byte.
    always_comb begin
        byte_v = eep[15:8];
        if (i_out_signed) begin
            if (eep < asfc_pkg::S_MIN) begin
                byte_v = asfc_pkg::BYTE_S_MIN;
            end else if (eep > asfc_pkg::S_MAX) begin
                byte_v = asfc_pkg::BYTE_S_MAX;
            end
        end else begin
            if (eep[asfc_pkg::VAL_W]) begin
                byte_v = asfc_pkg::BYTE_U_MIN;
            end else if (eep > asfc_pkg::U_MAX) begin
                byte_v = asfc_pkg::BYTE_U_MAX;
            end
        end
    end

    assign o_word = i_out_wide ? i_val[asfc_pkg::WORD_W-1:0] : {8'h00, byte_v};

endmodule

>>> hdl/audio_sample_format_converter_unit.sv
// Top level of the audio sample format converter: sequencer, sample state and output register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  input    | i_valid / o_ready        | i_sample_word, i_first, i_last
//  output   | o_valid / i_ready        | o_out_sample, o_run_last, o_end_of_sample
//  config   | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// One item at a time. An item that feeds no group close passes prep (and group unless held
// as a left word) before o_ready returns; one that leaves a result straight through also
// passes delta, quant and send and waits for the output. A group close runs the shared
// divider before delta; mono-to-stereo runs the group path twice per item. A stalled
// output holds the sequencer in its send state. Reset is synchronous and restores the
// configuration, sequencer, stream state and output valid; o_cfg_ready is always high.
module audio_sample_format_converter_unit #(
    parameter int MAX_SCALE = asfc_pkg::MAX_SCALE_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [asfc_pkg::WORD_W-1:0]          i_sample_word,
    input  logic                                 i_first,
    input  logic                                 i_last,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [asfc_pkg::WORD_W-1:0]          o_out_sample,
    output logic                                 o_run_last,
    output logic                                 o_end_of_sample,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [asfc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [asfc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int CW = $clog2(MAX_SCALE + 1);
    localparam int SW = asfc_pkg::VAL_W + CW;
    localparam int WW = asfc_pkg::WORD_W;
    localparam int VW = asfc_pkg::VAL_W;

    // Configuration registers.
    logic r_in_delta, r_in_signed, r_in_stereo, r_out_delta;
    logic r_out_signed, r_out_stereo, r_out_wide;
    logic [asfc_pkg::CFG_DATA_W-1:0] r_scale;

    // Sequencer and item registers.
    asfc_pkg::t_state r_state, n_state;
    asfc_pkg::t_ctrl  ctl;
    logic [WW-1:0]    r_word;
    logic             r_last;
    logic             r_dup;
    logic             r_second;
    logic signed [VW-1:0] r_gval;
    logic signed [VW-1:0] r_fval;

    // Stream state.
    logic [WW-1:0]                    r_dec_sum;
    logic [WW-1:0]                    r_enc_prev;
    logic [asfc_pkg::DITHER_W-1:0]    r_dither;
    logic [WW-1:0]                    r_held;
    logic                             r_phase;
    logic signed [SW-1:0]             r_gsum;
    logic [CW-1:0]                    r_gcnt;

    // Output register.
    logic            r_out_valid;
    logic [WW-1:0]   r_out_sample;
    logic            r_run_last;
    logic            r_eos;

    // Datapath nets.
    logic [WW-1:0]        w_dec;
    logic [WW-1:0]        w_pre;
    logic [WW-1:0]        w_flip;
    logic signed [VW-1:0] v_cur;
    logic signed [VW-1:0] v_left;
    logic signed [VW:0]   pair_sum;
    logic signed [VW:0]   pair_rnd;
    logic signed [VW-1:0] pair_avg;
    logic                 m_s2m;
    logic                 m_m2s;
    logic                 hold_left;
    logic [CW-1:0]        s_eff;
    logic                 s_zero;
    logic [CW-1:0]        cnt_new;
    logic signed [SW-1:0] sum_new;
    logic                 flush;
    logic                 close;
    logic                 first_of_two;
    logic                 c2_emits;
    logic signed [VW:0]   delta;
    logic                 div_done;
    logic signed [VW-1:0] div_quot;
    logic [WW-1:0]        q_word;
    logic [asfc_pkg::DITHER_W-1:0] q_dither;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_delta   <= 1'b0;
            r_in_signed  <= 1'b1;
            r_in_stereo  <= 1'b0;
            r_out_delta  <= 1'b0;
            r_out_signed <= 1'b1;
            r_out_stereo <= 1'b0;
            r_out_wide   <= 1'b1;
            r_scale      <= '0;
        end else if (i_cfg_valid) begin
            unique case (asfc_pkg::t_cfg_idx'(i_cfg_index))
                asfc_pkg::CFG_IN_DELTA:   r_in_delta   <= i_cfg_data[0];
                asfc_pkg::CFG_IN_SIGNED:  r_in_signed  <= i_cfg_data[0];
                asfc_pkg::CFG_IN_STEREO:  r_in_stereo  <= i_cfg_data[0];
                asfc_pkg::CFG_OUT_DELTA:  r_out_delta  <= i_cfg_data[0];
                asfc_pkg::CFG_OUT_SIGNED: r_out_signed <= i_cfg_data[0];
                asfc_pkg::CFG_OUT_STEREO: r_out_stereo <= i_cfg_data[0];
                asfc_pkg::CFG_OUT_WIDE:   r_out_wide   <= i_cfg_data[0];
                asfc_pkg::CFG_SCALE:      r_scale      <= i_cfg_data;
            endcase
        end
    end

    // Front end: delta decode, sign flip and pair averaging.
    assign w_dec    = r_dec_sum + r_word;
    assign w_pre    = r_in_delta ? w_dec : r_word;
    assign w_flip   = w_pre ^ ((r_in_signed != r_out_signed) ? asfc_pkg::SIGN_MASK : '0);
    assign v_cur    = asfc_pkg::as_value(w_flip, r_out_signed);
    assign v_left   = asfc_pkg::as_value(r_held, r_out_signed);
    assign pair_sum = (VW + 1)'(v_left) + (VW + 1)'(v_cur);
    assign pair_rnd = pair_sum + $signed({{VW{1'b0}}, pair_sum[VW]});
    assign pair_avg = pair_rnd[VW:1];
    assign m_s2m    = r_in_stereo & ~r_out_stereo;
    assign m_m2s    = ~r_in_stereo & r_out_stereo;
    assign hold_left = m_s2m & ~r_phase & ~r_last;

    // Grouping: effective size, running sum and close decision.
    assign s_eff   = (int'(r_scale) > MAX_SCALE) ? CW'(MAX_SCALE) : CW'(r_scale);
    assign s_zero  = (s_eff == '0);
    assign cnt_new = r_gcnt + 1'b1;
    assign sum_new = r_gsum + SW'(r_gval);
    assign first_of_two = r_dup & ~r_second;
    assign flush   = r_last & ~first_of_two;
    assign close   = (cnt_new >= s_eff) | flush;

    // Whether the second duplicate call will produce a result, seen after the first.
    assign c2_emits = s_zero | r_last | (cnt_new >= s_eff);

    // Output delta encode.
    assign delta = (VW + 1)'(r_fval) - (VW + 1)'(asfc_pkg::as_value(r_enc_prev, r_out_signed));

    // Shared divider for group averages.
    asfc_div #(
        .SUM_W (SW),
        .CNT_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctl.grp_close),
        .i_dividend (sum_new),
        .i_divisor  (cnt_new),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Word or dithered byte.
    asfc_quant u_quant (
        .i_val        (r_fval),
        .i_dither     (r_dither),
        .i_out_signed (r_out_signed),
        .i_out_wide   (r_out_wide),
        .o_word       (q_word),
        .o_dither     (q_dither)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            asfc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = asfc_pkg::ST_PREP;
                end
            end
            asfc_pkg::ST_PREP: begin
                n_state = hold_left ? asfc_pkg::ST_IDLE : asfc_pkg::ST_GROUP;
            end
            asfc_pkg::ST_GROUP: begin
                if (s_zero) begin
                    n_state = asfc_pkg::ST_DELTA;
                end else if (close) begin
                    n_state = asfc_pkg::ST_DIV;
                end else if (!first_of_two) begin
                    n_state = asfc_pkg::ST_IDLE;
                end
            end
            asfc_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = asfc_pkg::ST_DELTA;
                end
            end
            asfc_pkg::ST_DELTA: begin
                n_state = asfc_pkg::ST_QUANT;
            end
            asfc_pkg::ST_QUANT: begin
                n_state = asfc_pkg::ST_SEND;
            end
            asfc_pkg::ST_SEND: begin
                if (i_ready) begin
                    n_state = first_of_two ? asfc_pkg::ST_GROUP : asfc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = asfc_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath strobes for the current state.
    always_comb begin
        ctl = '0;
        unique case (r_state)
            asfc_pkg::ST_IDLE: begin
                ctl.ld_in = i_valid;
            end
            asfc_pkg::ST_PREP: begin
                ctl.prep = 1'b1;
            end
            asfc_pkg::ST_GROUP: begin
                ctl.grp_bypass = s_zero;
                ctl.grp_close  = ~s_zero & close;
                ctl.grp_acc    = ~s_zero & ~close;
                ctl.to_second  = ~s_zero & ~close & first_of_two;
            end
            asfc_pkg::ST_DIV: begin
                ctl.ld_quot = div_done;
            end
            asfc_pkg::ST_DELTA: begin
                ctl.do_delta = r_out_delta;
            end
            asfc_pkg::ST_QUANT: begin
                ctl.ld_out = 1'b1;
            end
            asfc_pkg::ST_SEND: begin
                ctl.out_done  = i_ready;
                ctl.to_second = i_ready & first_of_two;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= asfc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stream state: restart on a first word, then updates from each stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_sum  <= '0;
            r_enc_prev <= '0;
            r_dither   <= asfc_pkg::DITHER_INIT;
            r_held     <= '0;
            r_phase    <= 1'b0;
            r_gsum     <= '0;
            r_gcnt     <= '0;
            r_dup      <= 1'b0;
            r_second   <= 1'b0;
        end else begin
            if (ctl.ld_in && i_first) begin
                r_dec_sum  <= '0;
                r_enc_prev <= '0;
                r_dither   <= asfc_pkg::DITHER_INIT;
                r_held     <= '0;
                r_phase    <= 1'b0;
                r_gsum     <= '0;
                r_gcnt     <= '0;
            end
            if (ctl.prep) begin
                if (r_in_delta) begin
                    r_dec_sum <= w_dec;
                end
                if (hold_left) begin
                    r_held  <= w_flip;
                    r_phase <= 1'b1;
                end else if (r_last || m_s2m) begin
                    r_phase <= 1'b0;
                end
                r_dup    <= m_m2s;
                r_second <= 1'b0;
            end
            if (ctl.grp_close) begin
                r_gsum <= '0;
                r_gcnt <= '0;
            end
            if (ctl.grp_acc) begin
                r_gsum <= sum_new;
                r_gcnt <= cnt_new;
            end
            if (ctl.to_second) begin
                r_second <= 1'b1;
            end
            if (ctl.do_delta) begin
                r_enc_prev <= r_fval[WW-1:0];
            end
            if (ctl.ld_out && !r_out_wide) begin
                r_dither <= q_dither;
            end
        end
    end

    // Item payload registers.
    always_ff @(posedge i_clk) begin
        if (ctl.ld_in) begin
            r_word <= i_sample_word;
            r_last <= i_last;
        end
        if (ctl.prep) begin
            r_gval <= (m_s2m && r_phase) ? pair_avg : v_cur;
        end
        if (ctl.grp_bypass) begin
            r_fval <= r_gval;
        end
        if (ctl.ld_quot) begin
            r_fval <= div_quot;
        end
        if (ctl.do_delta) begin
            r_fval <= asfc_pkg::as_value(delta[WW-1:0], r_out_signed);
        end
    end

    // Output register: loaded once per result, held until the transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (ctl.out_done) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld_out) begin
            r_out_sample <= q_word;
            r_run_last   <= first_of_two ? ~c2_emits : 1'b1;
            r_eos        <= (first_of_two ? ~c2_emits : 1'b1) & r_last;
        end
    end

    assign o_ready         = (r_state == asfc_pkg::ST_IDLE);
    assign o_valid         = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_run_last      = r_run_last;
    assign o_end_of_sample = r_eos;

endmodule

>>> hdl/asfc_chk.sv
// Port-level checker for the audio sample format converter, bound to the top level.
module asfc_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [asfc_pkg::WORD_W-1:0]   o_out_sample,
    input logic                          o_run_last,
    input logic                          o_end_of_sample
);

    // The block never takes a word while a result is still on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while a result is pending");

    // The end-of-sample marker only sits on the last result of an item.
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_sample |-> o_run_last)
        else $error("end of sample on a result that is not the item's last");

    // An accepted word keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after an input transfer");

    // A result that is not the item's last is followed by more work, not a new word.
    a_more_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_last |=> !o_ready)
        else $error("input ready before the item's results are complete");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_sample))
        else $error("stalled result changed or dropped");

endmodule

bind audio_sample_format_converter_unit asfc_chk u_asfc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_out_sample    (o_out_sample),
    .o_run_last      (o_run_last),
    .o_end_of_sample (o_end_of_sample)
);

>>> tb/audio_sample_format_converter_unit_tb.sv
// Self-checking testbench for the audio sample format converter unit.
module audio_sample_format_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import asfc_pkg::*;

    // One converted word as it leaves the output channel.
    typedef struct packed {
        logic [WORD_W-1:0] smp;
        logic              run_last;
        logic              eos;
    } conv_word_t;

    // One row of the directed table: a register write or an input word.
    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t               kind;
        t_cfg_idx                idx;
        logic [CFG_DATA_W-1:0]   data;
        logic [WORD_W-1:0]       word;
        logic                    first;
        logic                    last;
        logic                    typed;
        conv_word_t              res;
    } stim_row_t;

    localparam conv_word_t NO_RES = '0;
    localparam int N_DIR       = 40;
    localparam int N_PHASES    = 14;
    localparam int PER_PHASE   = 92;
    localparam int SETTLE_CYC  = 64;
    localparam int HOLD_CYCLES = 300;

    // Directed table: reset defaults, range extremes, clamping, pairing, duplication,
    // grouping with flush, oversized and mid-group scale, and both delta coders.
    localparam stim_row_t DIR_ROWS [N_DIR] = '{
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0000, 1'b1, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h7FFF, 1'b0, 1'b0, 1'b1, '{16'h7FFF, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h8000, 1'b0, 1'b0, 1'b1, '{16'h8000, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'hFFFF, 1'b0, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_OUT_WIDE,   5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h7FFF, 1'b1, 1'b0, 1'b1, '{16'h007F, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h8000, 1'b0, 1'b1, 1'b1, '{16'h0080, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_OUT_SIGNED, 5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h7FFF, 1'b0, 1'b1, 1'b1, '{16'h00FF, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_OUT_SIGNED, 5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_OUT_WIDE,   5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_IN_STEREO,  5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h1000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h3000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0001, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h8000, 1'b0, 1'b1, 1'b1, '{16'h8000, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_IN_STEREO,  5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_OUT_STEREO, 5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h4321, 1'b1, 1'b1, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_OUT_STEREO, 5'd0,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_SCALE,      5'd3,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0010, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0020, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0030, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'hFFF0, 1'b0, 1'b1, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_SCALE,      5'd31, 16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h7FFF, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h7FFF, 1'b0, 1'b1, 1'b1, '{16'h7FFF, 1'b1, 1'b1}},
        '{ROW_CFG,  CFG_SCALE,      5'd4,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0100, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0200, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_SCALE,      5'd2,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0300, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_SCALE,      5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_IN_DELTA,   5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_CFG,  CFG_OUT_DELTA,  5'd1,  16'h0000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'h0005, 1'b1, 1'b0, 1'b0, NO_RES},
        '{ROW_ITEM, CFG_IN_DELTA,   5'd0,  16'hFFFF, 1'b0, 1'b1, 1'b0, NO_RES}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic [WORD_W-1:0]     i_sample_word;
    logic                  i_first;
    logic                  i_last;
    logic                  o_valid;
    logic                  i_ready;
    logic [WORD_W-1:0]     o_out_sample;
    logic                  o_run_last;
    logic                  o_end_of_sample;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predictor copy of the registers.
    logic              cf_in_delta, cf_in_signed, cf_in_stereo, cf_out_delta;
    logic              cf_out_signed, cf_out_stereo, cf_out_wide;
    logic [4:0]        cf_scale;

    // Predictor copy of the stream state.
    logic [WORD_W-1:0] run_sum;
    logic [WORD_W-1:0] prev_out;
    logic [WORD_W-1:0] left_word;
    logic [7:0]        dith;
    logic              pair_odd;
    int                grp_total;
    int                grp_n;

    conv_word_t item_words[$];
    conv_word_t pending_samples[$];
    int         mismatches = 0;
    bit         quiet = 1'b0;
    bit         hold_off = 1'b0;

    audio_sample_format_converter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_word  (i_sample_word),
        .i_first        (i_first),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_sample   (o_out_sample),
        .o_run_last     (o_run_last),
        .o_end_of_sample(o_end_of_sample),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Reads a word in the output domain: signed or unsigned by out_signed.
    function automatic int word_value(logic [WORD_W-1:0] w);
        return cf_out_signed ? int'($signed(w)) : int'({16'd0, w});
    endfunction

    function automatic void restart_stream();
        run_sum   = '0;
        prev_out  = '0;
        left_word = '0;
        dith      = DITHER_INIT;
        pair_odd  = 1'b0;
        grp_total = 0;
        grp_n     = 0;
    endfunction

    function automatic void reset_model();
        cf_in_delta   = 1'b0;
        cf_in_signed  = 1'b1;
        cf_in_stereo  = 1'b0;
        cf_out_delta  = 1'b0;
        cf_out_signed = 1'b1;
        cf_out_stereo = 1'b0;
        cf_out_wide   = 1'b1;
        cf_scale      = '0;
        restart_stream();
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        case (idx)
            CFG_IN_DELTA:   cf_in_delta   = d[0];
            CFG_IN_SIGNED:  cf_in_signed  = d[0];
            CFG_IN_STEREO:  cf_in_stereo  = d[0];
            CFG_OUT_DELTA:  cf_out_delta  = d[0];
            CFG_OUT_SIGNED: cf_out_signed = d[0];
            CFG_OUT_STEREO: cf_out_stereo = d[0];
            CFG_OUT_WIDE:   cf_out_wide   = d[0];
            CFG_SCALE:      cf_scale      = d;
            default: ;
        endcase
    endfunction

    // Delta encode, then either the plain word or the dithered and clamped byte.
    function automatic void emit_value(int v);
        int               diff;
        int               acc;
        logic [WORD_W-1:0] word;
        conv_word_t       r;
        if (cf_out_delta) begin
            diff     = v - word_value(prev_out);
            prev_out = v[15:0];
            v        = word_value(diff[15:0]);
        end
        if (cf_out_wide) begin
            word = v[15:0];
        end else begin
            acc  = v + int'({24'd0, dith});
            dith = acc[7:0];
            if (cf_out_signed) begin
                if (acc < -32768) acc = -32768;
                if (acc > 32767) acc = 32767;
                acc  = acc + 32768;
                word = {8'd0, acc[15:8] ^ 8'h80};
            end else begin
                if (acc < 0) acc = 0;
                if (acc > 65535) acc = 65535;
                word = {8'd0, acc[15:8]};
            end
        end
        r.smp      = word;
        r.run_last = 1'b0;
        r.eos      = 1'b0;
        item_words.push_back(r);
    endfunction

    // Averaging downsample; sizes above the maximum act as the maximum.
    function automatic void group_value(int v, logic flush);
        int lim;
        int avg;
        lim = (cf_scale > MAX_SCALE_DEF) ? MAX_SCALE_DEF : int'(cf_scale);
        if (lim == 0) begin
            emit_value(v);
        end else begin
            grp_total += v;
            grp_n++;
            if (grp_n >= lim || flush) begin
                avg       = grp_total / grp_n;
                grp_total = 0;
                grp_n     = 0;
                emit_value(avg);
            end
        end
    endfunction

    // Works out the converted words that one input transfer produces.
    function automatic void convert_word(logic [WORD_W-1:0] w, logic f, logic l);
        logic [WORD_W-1:0] x;
        int                v;
        conv_word_t        r;
        item_words.delete();
        if (f) restart_stream();
        x = w;
        if (cf_in_delta) begin
            run_sum = run_sum + w;
            x       = run_sum;
        end
        if (cf_in_signed != cf_out_signed) x = x ^ SIGN_MASK;
        v = word_value(x);
        if (cf_in_stereo && !cf_out_stereo) begin
            if (!pair_odd) begin
                // A left word that ends the sample goes out alone.
                if (l) begin
                    group_value(v, 1'b1);
                end else begin
                    left_word = x;
                    pair_odd  = 1'b1;
                end
            end else begin
                pair_odd = 1'b0;
                group_value((word_value(left_word) + v) / 2, l);
            end
        end else if (!cf_in_stereo && cf_out_stereo) begin
            group_value(v, 1'b0);
            group_value(v, l);
        end else begin
            group_value(v, l);
        end
        if (l) pair_odd = 1'b0;
        if (item_words.size() > 0) begin
            r          = item_words[item_words.size() - 1];
            r.run_last = 1'b1;
            r.eos      = l;
            item_words[item_words.size() - 1] = r;
        end
        foreach (item_words[k]) pending_samples.push_back(item_words[k]);
    endfunction

    // Offers one word and holds it until the transfer completes.
    task automatic send_word(logic [WORD_W-1:0] w, logic f, logic l);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_sample_word <= w;
        i_first       <= f;
        i_last        <= l;
        do @(posedge i_clk); while (!o_ready);
        convert_word(w, f, l);
    endtask

    // Random gap on the input side.
    task automatic maybe_gap();
        if (!quiet && $urandom_range(99) < 16) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge i_clk);
        end
    endtask

    // Drops the input valid and lets every pending word drain, plus a margin for
    // items that leave nothing behind.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        logic [WORD_W-1:0] corner [4];
        corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
        case ($urandom_range(7))
            0: return corner[$urandom_range(3)];
            1: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            4, 5, 6, 7: return 5'($urandom_range(1, 4));
            8: return 5'($urandom_range(5, 16));
            default: return 5'($urandom_range(17, 31));
        endcase
    endfunction

    // Receiver: random stalls, a quiet stretch, and one long hold-off.
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end else begin
                i_ready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // Compares each output transfer with the oldest pending word.
    always @(posedge i_clk) begin : out_check
        conv_word_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected transfer: out_sample %h", o_out_sample);
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                if (o_out_sample !== want.smp) begin
                    $error("out_sample: expected %h, got %h", want.smp, o_out_sample);
                    mismatches++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, o_run_last);
                    mismatches++;
                end
                if (o_end_of_sample !== want.eos) begin
                    $error("end_of_sample: expected %b, got %b", want.eos,
                           o_end_of_sample);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random phases of settings.
    initial begin
        int                    len;
        int                    sent;
        logic                  f;
        logic                  l;
        logic [CFG_DATA_W-1:0] d;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_sample_word = '0;
        i_first       = 1'b0;
        i_last        = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_IN_DELTA;
        i_cfg_data    = '0;
        reset_model();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; a typed result stands in for the predicted one.
        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG) begin
                settle();
                write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
            end else begin
                send_word(DIR_ROWS[r].word, DIR_ROWS[r].first, DIR_ROWS[r].last);
                if (DIR_ROWS[r].typed)
                    pending_samples[pending_samples.size() - 1] = DIR_ROWS[r].res;
                maybe_gap();
            end
        end

        // Random phases: all-low and all-high settings first, then random ones.
        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            for (int k = 0; k < 8; k++) begin
                if (p == 0) d = '0;
                else if (p == 1) d = '1;
                else if (t_cfg_idx'(k) == CFG_SCALE) d = pick_scale();
                else d = 5'($urandom_range(31));
                write_reg(t_cfg_idx'(k), d);
            end
            quiet = (p == 3);
            if (p == 5) hold_off = 1'b1;
            sent = 0;
            // Mostly well-formed samples, with first and last now and then misplaced.
            while (sent < PER_PHASE) begin
                len = $urandom_range(1, 24);
                for (int k = 0; k < len; k++) begin
                    f = (k == 0);
                    l = (k == len - 1);
                    if ($urandom_range(19) == 0) f = ~f;
                    if ($urandom_range(19) == 0) l = ~l;
                    send_word(rand_word(), f, l);
                    maybe_gap();
                    sent++;
                end
            end
            quiet = 1'b0;
        end

        settle();
        if (mismatches == 0) begin
            $display("audio_sample_format_converter_unit_tb: clean");
        end else begin
            $display("audio_sample_format_converter_unit_tb: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("audio_sample_format_converter_unit_tb: errors");
        $finish;
    end

endmodule

>>> files.f
hdl/asfc_pkg.sv
hdl/asfc_div.sv
hdl/asfc_quant.sv
hdl/audio_sample_format_converter_unit.sv
hdl/asfc_chk.sv
tb/audio_sample_format_converter_unit_tb.sv
